>>> src/sast_pkg.sv
// Shared types and constants for the set-associative search table.
package sast_pkg;

  localparam int unsigned WayCount    = 4;
  localparam int unsigned EntryWidth  = 64;
  localparam int unsigned SaltCount   = 6;
  localparam int unsigned BucketSize  = 10;
  localparam int unsigned DepthMargin = 4;
  localparam logic [1:0]  BoundNone   = 2'd0;
  localparam logic [1:0]  BoundExact  = 2'd3;

  localparam logic [2:0] RegSalt0    = 3'd0;
  localparam logic [2:0] RegSalt5    = 3'd5;
  localparam logic [2:0] RegAge      = 3'd6;
  localparam logic [2:0] RegMate     = 3'd7;

  localparam logic KindProbe = 1'b0;
  localparam logic KindStore = 1'b1;

  typedef struct packed {
    logic [4:0]  age;
    logic        pv;
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] score;
    logic [15:0] move;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] pos_key;
    logic [6:0]  fifty_move_count;
    logic [7:0]  ply;
    logic [15:0] store_score;
    logic [15:0] store_move;
    logic [7:0]  store_depth;
    logic [1:0]  store_bound;
    logic        store_pv;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        written;
    logic [15:0] found_move;
    logic [15:0] found_score;
    logic [7:0]  found_depth;
    logic [1:0]  found_bound;
    logic        found_pv;
  } rsp_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StDecide,
    StOut
  } state_e;

  typedef struct packed {
    logic capture;
    logic read;
    logic decide;
  } cmd_t;

  // Bucket of the fifty-move count: the count divided by BucketSize, capped at 12.
  function automatic logic [3:0] bucket_of(input logic [6:0] count);
    logic [3:0] b;
    b = 4'd0;
    for (int k = 1; k < 13; k++) begin
      if (count >= 7'(k * BucketSize)) b = 4'(k);
    end
    return b;
  endfunction

endpackage

>>> src/set_associative_search_table_core.sv
// Top level of the four-way set-associative search table.
// Steps from an accepted input beat to its result beat: capture with
//   cluster hash, memory read, match/replace decision into the output register.
// Flow: one item at a time; no new input beat is taken until the result beat of
//   the last one is taken, so a store is seen by the next probe.
// Reset: async active low; afterward a clearing pass over all CLUSTERS clusters zeroes
//   the cluster memory, during which no input beat is taken.
module set_associative_search_table_core
  import sast_pkg::*;
#(
  parameter int unsigned CLUSTERS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata, low bit up: pos_key[63:0], fifty_move_count[70:64], ply[78:71],
  // store_score[94:79], store_move[110:95], store_depth[118:111],
  // store_bound[120:119], store_pv[121], zero pad to 128
  input  logic [127:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // kind
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata, low bit up: hit[0], written[1], found_move[17:2], found_score[33:18],
  // found_depth[41:34], found_bound[43:42], found_pv[44], zero pad to 48
  output logic [47:0]  m_axis_tdata
);

  logic [63:0] salt_q [SaltCount];
  logic [4:0]  age_q;
  logic [14:0] mate_q;
  logic [2:0]  reg_idx;
  logic        wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SaltCount; k++) salt_q[k] <= '0;
      age_q  <= '0;
      mate_q <= 15'd31000;
    end else if (wr) begin
      if (reg_idx <= RegSalt5) salt_q[reg_idx] <= pwdata;
      else if (reg_idx == RegAge) age_q <= pwdata[4:0];
      else if (reg_idx == RegMate) mate_q <= pwdata[14:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx <= RegSalt5)     prdata = salt_q[reg_idx];
    else if (reg_idx == RegAge)  prdata = {59'd0, age_q};
    else if (reg_idx == RegMate) prdata = {49'd0, mate_q};
  end

  // Unpack input beat.
  req_t req;
  assign req.kind             = s_axis_tuser;
  assign req.pos_key          = s_axis_tdata[63:0];
  assign req.fifty_move_count = s_axis_tdata[70:64];
  assign req.ply              = s_axis_tdata[78:71];
  assign req.store_score      = s_axis_tdata[94:79];
  assign req.store_move       = s_axis_tdata[110:95];
  assign req.store_depth      = s_axis_tdata[118:111];
  assign req.store_bound      = s_axis_tdata[120:119];
  assign req.store_pv         = s_axis_tdata[121];

  cmd_t cmd;
  rsp_t rsp;
  logic busy, clr_busy, in_fire, out_fire;

  assign s_axis_tready = !busy && !clr_busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = m_axis_tvalid && m_axis_tready;

  sast_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .out_fire_i  (out_fire),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd)
  );

  sast_datapath #(.Clusters(CLUSTERS)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .req_i      (req),
    .salt_i     (salt_q),
    .age_i      (age_q),
    .mate_i     (mate_q),
    .rsp_o      (rsp),
    .clr_busy_o (clr_busy)
  );

  assign m_axis_tdata = {3'd0, rsp.found_pv, rsp.found_bound, rsp.found_depth,
                         rsp.found_score, rsp.found_move, rsp.written, rsp.hit};

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accepted while result pending");
  a_one_of_hit_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1])) else $error("hit and written");
  a_ready_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_axis_tready) else $error("ready during clear");
`endif

endmodule

>>> src/sast_ctrl.sv
// Controller state machine for the table: read, decide, deliver.
module sast_ctrl
  import sast_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_fire_i,
  input  logic out_fire_i,
  output logic busy_o,
  output logic out_valid_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    busy_o      = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        busy_o = 1'b0;
        if (in_fire_i) begin
          cmd_o.capture = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.read = 1'b1;
        state_d = StDecide;
      end
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d = StOut;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_fire_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

`ifndef SYNTHESIS
  a_read_after_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> cmd_o.read) else $error("read did not follow capture");
  a_decide_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.read |=> cmd_o.decide) else $error("decide did not follow read");
  a_out_after_decide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.decide |=> out_valid_o) else $error("no result after decide");
`endif

endmodule

>>> src/sast_datapath.sv
// Datapath: cluster index, cluster memory, probe match and store replacement.
module sast_datapath
  import sast_pkg::*;
#(
  parameter int unsigned Clusters = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  req_t        req_i,
  input  logic [63:0] salt_i [SaltCount],
  input  logic [4:0]  age_i,
  input  logic [14:0] mate_i,
  output rsp_t        rsp_o,
  output logic        clr_busy_o
);

  localparam int unsigned IdxW = (Clusters > 1) ? $clog2(Clusters) : 1;
  localparam int unsigned RowW = EntryWidth * WayCount;

  // Clear sweep over clusters after reset.
  logic [IdxW:0] clr_cnt_q;
  logic          clr_busy;
  assign clr_busy   = clr_cnt_q < (IdxW+1)'(Clusters);
  assign clr_busy_o = clr_busy;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       clr_cnt_q <= '0;
    else if (clr_busy) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  req_t        req_q;
  logic [IdxW-1:0] idx_q;
  logic [3:0]  bucket;
  logic [63:0] salted;
  logic [95:0] prod;
  logic [31:0] cl_hi;

  assign bucket = bucket_of(req_i.fifty_move_count);
  assign salted = req_i.pos_key ^
                  ((bucket < 4'(SaltCount)) ? salt_i[bucket[2:0]] : 64'd0);
  // High 32 bits of the 96-bit product salted * Clusters; cluster count fits 32 bits.
  assign prod  = 96'(salted) * 96'(32'(Clusters));
  assign cl_hi = prod[95:64];

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
      idx_q <= (cl_hi >= 32'(Clusters)) ? IdxW'(Clusters - 1) : cl_hi[IdxW-1:0];
    end
  end

  logic [RowW-1:0] mem [Clusters];
  logic [RowW-1:0] row_q;
  logic            wr_en;
  logic [RowW-1:0] wr_row;

  always_ff @(posedge clk_i) begin
    if (clr_busy)   mem[clr_cnt_q[IdxW-1:0]] <= '0;
    else if (wr_en) mem[idx_q] <= wr_row;
    if (cmd_i.read) row_q <= mem[idx_q];
  end

  entry_t ways [WayCount];
  always_comb begin
    for (int w = 0; w < WayCount; w++) ways[w] = row_q[w*EntryWidth +: EntryWidth];
  end

  logic [15:0] tag;
  logic signed [16:0] mate_s;
  assign tag    = req_q.pos_key[15:0];
  assign mate_s = {2'b00, mate_i};

  // Probe: first valid tag match.
  logic        hit;
  entry_t      hent;
  always_comb begin
    hit  = 1'b0;
    hent = '0;
    for (int w = WayCount - 1; w >= 0; w--) begin
      if (ways[w].tag == tag && ways[w].bound != BoundNone) begin
        hit  = 1'b1;
        hent = ways[w];
      end
    end
  end

  logic signed [16:0] hsc;
  logic [15:0]        hscore;
  assign hsc = 17'(signed'(hent.score));
  always_comb begin
    hscore = hent.score;
    if (hsc < -mate_s) hscore = hent.score + {8'd0, req_q.ply};
    if (hsc > mate_s)  hscore = hent.score - {8'd0, req_q.ply};
  end

  // Store: replacement choice.
  logic [1:0]        pick;
  logic              found;
  logic signed [9:0] best, val;
  logic [4:0]        rel;
  always_comb begin
    pick  = 2'd0;
    found = 1'b0;
    best  = '0;
    for (int w = 0; w < WayCount; w++) begin
      rel = age_i - ways[w].age;
      val = 10'(signed'({1'b0, ways[w].depth})) - 10'(signed'({1'b0, rel, 1'b0}));
      if (!found) begin
        if (ways[w].tag == tag || ways[w].bound == BoundNone) begin
          pick  = 2'(w);
          found = 1'b1;
        end else if (w == 0 || val < best) begin
          pick = 2'(w);
          best = val;
        end
      end
    end
  end

  entry_t old_e, new_e;
  logic   skip;
  logic   [9:0] need;
  logic signed [16:0] ssc;
  assign old_e = ways[pick];
  assign need  = 10'(req_q.store_depth) + 10'(DepthMargin) + {8'd0, req_q.store_pv, 1'b0};
  assign skip  = old_e.tag == tag && req_q.store_bound != BoundExact &&
                 need <= 10'(old_e.depth) && old_e.age == age_i;
  assign ssc   = 17'(signed'(req_q.store_score));

  always_comb begin
    new_e       = old_e;
    new_e.tag   = tag;
    if (req_q.store_move != 16'd0 || old_e.tag != tag) new_e.move = req_q.store_move;
    new_e.score = req_q.store_score;
    if (ssc < -mate_s) new_e.score = req_q.store_score - {8'd0, req_q.ply};
    if (ssc > mate_s)  new_e.score = req_q.store_score + {8'd0, req_q.ply};
    new_e.depth = req_q.store_depth;
    new_e.bound = req_q.store_bound;
    new_e.pv    = req_q.store_pv;
    new_e.age   = age_i;
  end

  always_comb begin
    wr_row = row_q;
    wr_row[pick*EntryWidth +: EntryWidth] = new_e;
  end
  assign wr_en = cmd_i.decide && req_q.kind == KindStore && !skip;

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      rsp_o <= '0;
      if (req_q.kind == KindStore) begin
        rsp_o.written <= !skip;
      end else if (hit) begin
        rsp_o.hit         <= 1'b1;
        rsp_o.found_move  <= hent.move;
        rsp_o.found_score <= hscore;
        rsp_o.found_depth <= hent.depth;
        rsp_o.found_bound <= hent.bound;
        rsp_o.found_pv    <= hent.pv;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_write_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !cmd_i.capture) else $error("item taken during clear");
  a_probe_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decide && req_q.kind == KindProbe) |-> !wr_en) else $error("probe wrote");
  a_written_only_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.decide) && rsp_o.written |-> !rsp_o.hit) else $error("bad result");
`endif

endmodule
